// File: rtl/core/http_chunked_body_decoder_top_macros.svh
// Assertion macros used by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hcbd_pkg.sv
// Types, character codes and the hex digit decoder for the chunked body decoder.
`default_nettype none
package hcbd_pkg;

    localparam int C_OUT_COUNT_W = 24;
    localparam int C_MAX_OUT_W   = 24;

    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_LOW_A  = 8'h61;
    localparam logic [7:0] C_LOW_F  = 8'h66;
    localparam logic [7:0] C_UP_A   = 8'h41;
    localparam logic [7:0] C_UP_F   = 8'h46;
    localparam logic [7:0] C_TEN    = 8'd10;

    typedef enum logic [4:0] {
        PH_LINE     = 5'b00001,
        PH_DATA     = 5'b00010,
        PH_TRAIL    = 5'b00100,
        PH_TRAIL_CR = 5'b01000,
        PH_DONE     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       body_last;
    } t_item;

    typedef struct packed {
        logic [7:0]               data_byte;
        logic                     data_valid;
        logic                     done_res;
        logic                     ok;
        logic [C_OUT_COUNT_W-1:0] decoded_count;
    } t_result;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'b0;
        if (c inside {[C_ZERO:C_NINE]}) begin
            res = {1'b1, 4'(c - C_ZERO)};
        end else if (c inside {[C_LOW_A:C_LOW_F]}) begin
            res = {1'b1, 4'(c - C_LOW_A + C_TEN)};
        end else if (c inside {[C_UP_A:C_UP_F]}) begin
            res = {1'b1, 4'(c - C_UP_A + C_TEN)};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/http_chunked_body_decoder_top.sv
// An accepted item is held in the input register; its result is then registered
// in the result register. One raw byte is taken per cycle while the output does
// not stall; each byte updates the size, payload and trailer state combinationally
// between the registers. Bytes that produce no result still pass the input register.
// Reset is synchronous and active low: it clears all body state and sets max_out
// to all ones; there is no clearing pass.
`default_nettype none
module http_chunked_body_decoder_top
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS  = 32,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [C_MAX_OUT_W-1:0]   i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [7:0]               i_raw_byte,
    input  wire logic                     i_body_last,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [7:0]                    o_data_byte,
    output logic                          o_data_valid,
    output logic                          o_done_res,
    output logic                          o_ok,
    output logic [C_OUT_COUNT_W-1:0]      o_decoded_count
);

    logic [C_MAX_OUT_W-1:0] r_max_out;
    t_item                  in_item;
    t_item                  cur_item;
    logic                   free;
    logic                   go;
    logic                   emit;
    t_result                res;
    t_result                out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out <= '1;
        end else if (i_cfg_we) begin
            r_max_out <= i_cfg_wdata;
        end
    end

    assign in_item.raw_byte  = i_raw_byte;
    assign in_item.body_last = i_body_last;

    hcbd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (in_item),
        .i_free     (free),
        .o_in_stall (o_in_stall),
        .o_go       (go),
        .o_item     (cur_item)
    );

    hcbd_decode #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_item    (cur_item),
        .i_max_out (r_max_out),
        .o_emit    (emit),
        .o_res     (res)
    );

    hcbd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_data_byte     = out_res.data_byte;
    assign o_data_valid    = out_res.data_valid;
    assign o_done_res      = out_res.done_res;
    assign o_ok            = out_res.ok;
    assign o_decoded_count = out_res.decoded_count;

endmodule
`default_nettype wire

// File: rtl/core/hcbd_in_stage.sv
// Input register of the chunked body decoder.
`default_nettype none
module hcbd_in_stage
    import hcbd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_item i_item,
    input  wire logic  i_free,
    output logic       o_in_stall,
    output logic       o_go,
    output t_item      o_item
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    logic  accept;

    // Process the held item whenever the result register can take a result.
    assign o_go       = r_vld && i_free;
    assign o_in_stall = r_vld && !i_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_item     = r_item;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_go) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/hcbd_decode.sv
// Per-byte state update of the chunked body decoder: size line, payload, trailer.
`default_nettype none
`include "http_chunked_body_decoder_top_macros.svh"
module hcbd_decode
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS  = 32,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_go,
    input  wire t_item                  i_item,
    input  wire logic [C_MAX_OUT_W-1:0] i_max_out,
    output logic                        o_emit,
    output t_result                     o_res
);

    localparam int CMP_W = (COUNT_BITS > C_MAX_OUT_W) ? COUNT_BITS : C_MAX_OUT_W;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [SIZE_BITS-1:0]  r_chunk;
    logic [SIZE_BITS-1:0]  n_chunk;
    logic                  r_dig_end;
    logic                  n_dig_end;
    logic                  r_saw_cr;
    logic                  n_saw_cr;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;

    logic [7:0]            c;
    logic                  last;
    logic [4:0]            hex;

    // Size line step, on inputs chosen by the phase.
    logic [SIZE_BITS-1:0]  ln_chunk_in;
    logic                  ln_de_in;
    logic                  ln_scr_in;
    logic [SIZE_BITS-1:0]  ln_chunk;
    logic                  ln_de;
    logic                  ln_scr;
    t_phase                ln_phase;
    logic                  ln_zero;

    logic [SIZE_BITS-1:0]  chunk_dec;
    logic                  room;
    logic                  valid;
    logic                  zero_end;

    assign c    = i_item.raw_byte;
    assign last = i_item.body_last;
    assign hex  = hex_digit(c);

    always_comb begin
        ln_chunk_in = r_chunk;
        ln_de_in    = r_dig_end;
        ln_scr_in   = r_saw_cr;
        // A CR after payload not followed by LF opens an empty size line.
        if (r_phase == PH_TRAIL_CR) begin
            ln_de_in  = 1'b1;
            ln_scr_in = 1'b1;
        end
    end

    always_comb begin
        ln_chunk = ln_chunk_in;
        ln_de    = ln_de_in;
        ln_scr   = ln_scr_in;
        ln_phase = PH_LINE;
        ln_zero  = 1'b0;
        if (!ln_de_in && hex[4]) begin
            if (ln_chunk_in[SIZE_BITS-1 -: 4] != 4'b0) begin
                ln_chunk = '1;
            end else begin
                ln_chunk = {ln_chunk_in[SIZE_BITS-5:0], hex[3:0]};
            end
        end else begin
            ln_de = 1'b1;
            if (ln_scr_in && c == C_LF) begin
                ln_de  = 1'b0;
                ln_scr = 1'b0;
                if (ln_chunk_in == '0) begin
                    ln_phase = PH_DONE;
                    ln_zero  = 1'b1;
                end else begin
                    ln_phase = PH_DATA;
                end
            end else begin
                ln_scr = (c == C_CR);
            end
        end
    end

    assign chunk_dec = r_chunk - SIZE_BITS'(1);
    assign room      = (CMP_W'(r_cnt) < CMP_W'(i_max_out)) && (r_cnt != '1);

    always_comb begin
        n_phase   = r_phase;
        n_chunk   = r_chunk;
        n_dig_end = r_dig_end;
        n_saw_cr  = r_saw_cr;
        n_cnt     = r_cnt;
        valid     = 1'b0;
        zero_end  = 1'b0;
        case (r_phase)
            PH_LINE: begin
                n_chunk   = ln_chunk;
                n_dig_end = ln_de;
                n_saw_cr  = ln_scr;
                n_phase   = ln_phase;
                zero_end  = ln_zero;
            end
            PH_DATA: begin
                if (room) begin
                    n_cnt = r_cnt + COUNT_BITS'(1);
                    valid = 1'b1;
                end
                n_chunk = chunk_dec;
                if (chunk_dec == '0) begin
                    n_phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (c == C_CR) begin
                    n_phase = PH_TRAIL_CR;
                end else begin
                    n_chunk   = ln_chunk;
                    n_dig_end = ln_de;
                    n_saw_cr  = ln_scr;
                    n_phase   = ln_phase;
                    zero_end  = ln_zero;
                end
            end
            PH_TRAIL_CR: begin
                n_phase = PH_LINE;
                if (c != C_LF) begin
                    n_chunk   = ln_chunk;
                    n_dig_end = ln_de;
                    n_saw_cr  = ln_scr;
                    n_phase   = ln_phase;
                    zero_end  = ln_zero;
                end
            end
            default: begin
            end
        endcase
    end

    // A body already closed by a zero chunk reports nothing on its last byte.
    always_comb begin
        o_emit              = i_go && (valid || zero_end || (last && r_phase != PH_DONE));
        o_res.data_byte     = valid ? c : 8'h00;
        o_res.data_valid    = valid;
        o_res.done_res      = zero_end || last;
        o_res.ok            = zero_end || (last && n_phase != PH_DONE && n_cnt != '0);
        o_res.decoded_count = C_OUT_COUNT_W'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LINE;
            r_chunk   <= '0;
            r_dig_end <= 1'b0;
            r_saw_cr  <= 1'b0;
            r_cnt     <= '0;
        end else if (i_go) begin
            if (last) begin
                r_phase   <= PH_LINE;
                r_chunk   <= '0;
                r_dig_end <= 1'b0;
                r_saw_cr  <= 1'b0;
                r_cnt     <= '0;
            end else begin
                r_phase   <= n_phase;
                r_chunk   <= n_chunk;
                r_dig_end <= n_dig_end;
                r_saw_cr  <= n_saw_cr;
                r_cnt     <= n_cnt;
            end
        end
    end

    `HCBD_ASSERT_NOW(a_data_only_in_payload, o_emit && o_res.data_valid, r_phase == PH_DATA, "payload byte outside payload phase")
    `HCBD_ASSERT_NOW(a_payload_has_bytes, r_phase == PH_DATA, r_chunk != '0, "payload phase with nothing left")
    `HCBD_ASSERT_NOW(a_ok_needs_done, o_emit && o_res.ok, o_res.done_res, "ok without done")
    `HCBD_ASSERT_NXT(a_last_clears, i_go && last, r_phase == PH_LINE && r_cnt == '0, "state not cleared after last byte")

endmodule
`default_nettype wire

// File: rtl/core/hcbd_out_stage.sv
// Result register of the chunked body decoder.
`default_nettype none
module hcbd_out_stage
    import hcbd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_out_stall,
    output logic         o_free,
    output logic         o_out_valid,
    output t_result      o_res
);

    logic    r_vld;
    logic    n_vld;
    t_result r_res;

    assign o_free      = !r_vld || !i_out_stall;
    assign o_out_valid = r_vld;
    assign o_res       = r_res;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (o_free) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire
